// ===== rtl/chfi_pkg.sv =====
// ----------------------------------------------------------------------------
// chfi_pkg
// Shared types and constants for the coordinate hash find-or-insert block.
// ----------------------------------------------------------------------------
package chfi_pkg;

  localparam int unsigned COORD_W  = 24;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MUL_W    = 32;

  // golden-ratio fraction (sqrt(5)-1)/2 scaled by 2^32
  localparam logic [MUL_W-1:0] GOLDEN = 32'h9E37_79B9;

  localparam int unsigned DEF_BUCKETS = 256;
  localparam int unsigned DEF_NODES   = 1024;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_CREATED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PAIR,
    S_KEY,
    S_HASH,
    S_SCALE,
    S_HEAD,
    S_HEADRD,
    S_CHK,
    S_CMP,
    S_DONE
  } state_e;

endpackage

// ===== rtl/coordinate_hash_find_or_insert.sv =====
// Throughput: one item at a time, taken the cycle after the result is handed to
//   the output register; each chain node costs a store read and a compare.
// Reset: node count and handshakes clear at once; a clearing pass then zeroes
//   every bucket head, with no item accepted meanwhile.
// ----------------------------------------------------------------------------
// coordinate_hash_find_or_insert
// Cantor-pairing key, multiplicative hash, and find-or-insert in a chained
// node store.
// ----------------------------------------------------------------------------
module coordinate_hash_find_or_insert #(
  parameter int unsigned BUCKETS = chfi_pkg::DEF_BUCKETS,
  parameter int unsigned NODES   = chfi_pkg::DEF_NODES,
  localparam int unsigned NW     = $clog2(NODES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [chfi_pkg::COORD_W-1:0]  coord_x_i,
  input  logic [chfi_pkg::COORD_W-1:0]  coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [NW-1:0]                 node_number_o,
  output logic [chfi_pkg::STATUS_W-1:0] status_o
);

  localparam int unsigned CW  = chfi_pkg::COORD_W;
  localparam int unsigned MW  = chfi_pkg::MUL_W;
  localparam int unsigned BW  = $clog2(BUCKETS);
  localparam int unsigned PAW = $clog2(NODES);
  localparam int unsigned EW  = 2 * CW + NW;

  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);
  localparam logic [NW-1:0] NODES_N     = NW'(NODES);
  localparam logic [MW-1:0] BUCKETS_M   = MW'(BUCKETS);

  chfi_pkg::state_e state_q, state_d;

  logic [CW-1:0]     x_q, x_d, y_q, y_d;
  logic [CW:0]       sum_q, sum_d;
  logic [MW-1:0]     key_q, key_d;
  logic [2*MW-1:0]   prod_q;
  logic [MW-1:0]     mul_a, mul_b;
  logic [BW-1:0]     bucket_q, bucket_d;
  logic [BW-1:0]     clr_q, clr_d;
  logic [NW-1:0]     head_q, head_d;
  logic [NW-1:0]     cur_q, cur_d;
  logic [NW-1:0]     count_q, count_d;
  logic [NW-1:0]     cur_m1;
  logic [NW-1:0]     res_num_q, res_num_d;
  chfi_pkg::status_e res_st_q, res_st_d;

  logic              out_valid_q, out_valid_d;
  logic [NW-1:0]     out_num_q, out_num_d;
  chfi_pkg::status_e out_st_q, out_st_d;

  logic              hb_we;
  logic [BW-1:0]     hb_waddr, hb_raddr;
  logic [NW-1:0]     hb_wdata, hb_rdata;
  logic              ps_we;
  logic [EW-1:0]     ps_wdata, ps_rdata;
  logic [PAW-1:0]    ps_raddr;
  logic              ins_w;

  logic [CW-1:0]     e_x, e_y;
  logic [NW-1:0]     e_next;

  assign e_x    = ps_rdata[EW-1 -: CW];
  assign e_y    = ps_rdata[NW +: CW];
  assign e_next = ps_rdata[NW-1:0];
  assign cur_m1 = cur_q - 1'b1;

  // shared multiplier, product registered every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(mul_a) * 64'(mul_b);
  end

  chfi_ram #(
    .WIDTH (NW),
    .DEPTH (BUCKETS)
  ) u_heads (
    .clk_i   (clk_i),
    .we_i    (hb_we),
    .waddr_i (hb_waddr),
    .wdata_i (hb_wdata),
    .raddr_i (hb_raddr),
    .rdata_o (hb_rdata)
  );

  chfi_ram #(
    .WIDTH (EW),
    .DEPTH (NODES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (count_q[PAW-1:0]),
    .wdata_i (ps_wdata),
    .raddr_i (ps_raddr),
    .rdata_o (ps_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= chfi_pkg::S_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    sum_q     <= sum_d;
    key_q     <= key_d;
    bucket_q  <= bucket_d;
    head_q    <= head_d;
    cur_q     <= cur_d;
    res_num_q <= res_num_d;
    res_st_q  <= res_st_d;
    out_num_q <= out_num_d;
    out_st_q  <= out_st_d;
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    sum_d       = sum_q;
    key_d       = key_q;
    bucket_d    = bucket_q;
    head_d      = head_q;
    cur_d       = cur_q;
    clr_d       = clr_q;
    count_d     = count_q;
    res_num_d   = res_num_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_num_d   = out_num_q;
    out_st_d    = out_st_q;
    mul_a       = '0;
    mul_b       = '0;
    hb_we       = 1'b0;
    hb_waddr    = bucket_q;
    hb_wdata    = '0;
    hb_raddr    = bucket_q;
    ps_we       = 1'b0;
    ps_wdata    = {x_q, y_q, head_q};
    ps_raddr    = cur_m1[PAW-1:0];
    ins_w       = 1'b0;
    in_stall_o  = 1'b1;

    // drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      chfi_pkg::S_CLEAR: begin
        hb_we    = 1'b1;
        hb_waddr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LAST_BUCKET) begin
          state_d = chfi_pkg::S_IDLE;
        end
      end
      chfi_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          x_d     = coord_x_i;
          y_d     = coord_y_i;
          sum_d   = {1'b0, coord_x_i} + {1'b0, coord_y_i};
          state_d = chfi_pkg::S_PAIR;
        end
      end
      chfi_pkg::S_PAIR: begin
        mul_a   = MW'(sum_q);
        mul_b   = MW'({1'b0, sum_q} + 1'b1);
        state_d = chfi_pkg::S_KEY;
      end
      chfi_pkg::S_KEY: begin
        key_d   = MW'(y_q) + prod_q[MW:1];
        state_d = chfi_pkg::S_HASH;
      end
      chfi_pkg::S_HASH: begin
        mul_a   = key_q;
        mul_b   = chfi_pkg::GOLDEN;
        state_d = chfi_pkg::S_SCALE;
      end
      chfi_pkg::S_SCALE: begin
        mul_a   = prod_q[MW-1:0];
        mul_b   = BUCKETS_M;
        state_d = chfi_pkg::S_HEAD;
      end
      chfi_pkg::S_HEAD: begin
        bucket_d = prod_q[MW +: BW];
        hb_raddr = prod_q[MW +: BW];
        state_d  = chfi_pkg::S_HEADRD;
      end
      chfi_pkg::S_HEADRD: begin
        head_d  = hb_rdata;
        cur_d   = hb_rdata;
        state_d = chfi_pkg::S_CHK;
      end
      chfi_pkg::S_CHK: begin
        if (cur_q != '0 && cur_q <= count_q) begin
          state_d = chfi_pkg::S_CMP;
        end else if (count_q >= NODES_N) begin
          res_num_d = '0;
          res_st_d  = chfi_pkg::ST_FULL;
          state_d   = chfi_pkg::S_DONE;
        end else begin
          // push the new node at the chain head
          ins_w     = 1'b1;
          ps_we     = 1'b1;
          hb_we     = 1'b1;
          hb_wdata  = count_q + 1'b1;
          count_d   = count_q + 1'b1;
          res_num_d = count_q + 1'b1;
          res_st_d  = chfi_pkg::ST_CREATED;
          state_d   = chfi_pkg::S_DONE;
        end
      end
      chfi_pkg::S_CMP: begin
        if (e_x == x_q && e_y == y_q) begin
          res_num_d = cur_q;
          res_st_d  = chfi_pkg::ST_FOUND;
          state_d   = chfi_pkg::S_DONE;
        end else begin
          cur_d   = e_next;
          state_d = chfi_pkg::S_CHK;
        end
      end
      chfi_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_num_d   = res_num_q;
          out_st_d    = res_st_q;
          state_d     = chfi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = chfi_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign node_number_o = out_num_q;
  assign status_o      = out_st_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NODES_N)
    else $error("node count beyond store size");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_w |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not advance node count");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == chfi_pkg::ST_FULL) |-> count_q == NODES_N)
    else $error("full status while store has room");

  a_zero_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_num_q == '0) == (out_st_q == chfi_pkg::ST_FULL)))
    else $error("node number zero does not match full status");
`endif

endmodule

// ===== rtl/chfi_ram.sv =====
// ----------------------------------------------------------------------------
// chfi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chfi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/find_or_insert_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// find_or_insert_checker
// Watches both channels of the coordinate hash block. Keeps its own bucket
// chains and node store, predicts the outcome of every accepted point, and
// compares each result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module find_or_insert_checker #(
  parameter int unsigned BUCKETS = chfi_pkg::DEF_BUCKETS,
  parameter int unsigned NODES   = chfi_pkg::DEF_NODES,
  localparam int unsigned NW     = $clog2(NODES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [chfi_pkg::COORD_W-1:0]  coord_x_i,
  input  logic [chfi_pkg::COORD_W-1:0]  coord_y_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [NW-1:0]                 node_number_i,
  input  logic [chfi_pkg::STATUS_W-1:0] status_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned CW = chfi_pkg::COORD_W;

  typedef struct packed {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [NW-1:0] link;
  } point_node_t;

  typedef struct packed {
    logic [NW-1:0]     number;
    chfi_pkg::status_e status;
  } outcome_t;

  point_node_t   node_store[NODES];
  logic [NW-1:0] chain_head[BUCKETS];
  int unsigned   nodes_used;
  outcome_t      outcome_q[$];
  outcome_t      want;
  int            mismatches = 0;

  function automatic int unsigned bucket_of_point(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] y);
    logic [63:0] s;
    logic [63:0] key;
    logic [31:0] f;
    logic [63:0] scaled;
    s      = 64'(x) + 64'(y);
    key    = 64'(y) + ((s * (s + 64'd1)) >> 1);
    f      = key[31:0] * chfi_pkg::GOLDEN;
    scaled = (64'(f) * 64'(BUCKETS)) >> 32;
    if (scaled >= 64'(BUCKETS)) return BUCKETS - 1;
    return int'(scaled);
  endfunction

  function automatic outcome_t find_or_insert(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y);
    int unsigned b;
    int unsigned cur;
    int unsigned steps;
    outcome_t    res;
    b     = bucket_of_point(x, y);
    cur   = chain_head[b];
    steps = 0;
    // a link outside the created nodes, or an overlong walk, ends as a miss
    while (cur != 0 && cur <= nodes_used && cur <= NODES && steps < NODES) begin
      if (node_store[cur-1].px == x && node_store[cur-1].py == y) begin
        res.number = NW'(cur);
        res.status = chfi_pkg::ST_FOUND;
        return res;
      end
      cur = node_store[cur-1].link;
      steps++;
    end
    if (nodes_used >= NODES) begin
      res.number = '0;
      res.status = chfi_pkg::ST_FULL;
      return res;
    end
    nodes_used++;
    node_store[nodes_used-1] = '{px: x, py: y, link: chain_head[b]};
    chain_head[b] = NW'(nodes_used);
    res.number = NW'(nodes_used);
    res.status = chfi_pkg::ST_CREATED;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUCKETS; i++) chain_head[i] = '0;
      nodes_used = 0;
      outcome_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        outcome_q.push_back(find_or_insert(coord_x_i, coord_y_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: node %0d status %0d",
                                    node_number_i, status_i));
        end else begin
          want = outcome_q.pop_front();
          if (node_number_i !== want.number)
            report_mismatch($sformatf("node_number %0d, predicted %0d",
                                      node_number_i, want.number));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, predicted %s",
                                      status_i, want.status.name()));
        end
      end
    end
    pending_o    <= outcome_q.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives points into the coordinate hash block: a directed set of corner
// coordinates, then random points mixed with repeats of earlier ones, past
// the point where the node store fills. Both channels idle and stall at
// random. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CW            = chfi_pkg::COORD_W;
  localparam int unsigned NUM_W         = $clog2(chfi_pkg::DEF_NODES + 1);
  localparam int unsigned RANDOM_POINTS = 1630;
  localparam logic [CW-1:0] COORD_MAX   = '1;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [CW-1:0]                 coord_x_i;
  logic [CW-1:0]                 coord_y_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [NUM_W-1:0]              node_number_o;
  logic [chfi_pkg::STATUS_W-1:0] status_o;

  int                  fail_count;
  int                  pending;
  bit                  calm;
  logic [CW-1:0]       sent_x[$];
  logic [CW-1:0]       sent_y[$];

  always #5 clk_i = ~clk_i;

  coordinate_hash_find_or_insert dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .node_number_o (node_number_o),
    .status_o      (status_o)
  );

  find_or_insert_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .node_number_i (node_number_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // mostly no gap, sometimes a short gap, rarely a long stretch
  function automatic int unsigned draw_gap(input int unsigned quiet_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < quiet_pct) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_point(input logic [CW-1:0] x, input logic [CW-1:0] y);
    int unsigned gap;
    gap = draw_gap(60);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    // hold the item until the block takes it
    do @(posedge clk_i); while (in_stall_o);
    sent_x.push_back(x);
    sent_y.push_back(y);
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        hold = draw_gap(88);
        out_stall_i <= (hold != 0);
        if (hold != 0) hold--;
      end
    end
  end

  initial begin
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    int unsigned   pick;
    int unsigned   r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    coord_x_i   = '0;
    coord_y_i   = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_point('0, '0);
    send_point('0, '0);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, '0);
    send_point('0, COORD_MAX);
    send_point(24'h000001, 24'h000000);
    send_point(24'h000000, 24'h000001);
    send_point(24'hAAAAAA, 24'h555555);
    send_point(24'h555555, 24'hAAAAAA);
    send_point(24'h000080, 24'h0000FF);
    send_point(24'hFFFF00, 24'h0000FF);
    send_point(24'h800000, 24'h800000);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, '0);
    send_point('0, '0);

    // enough fresh points to fill the store, then keep probing past full
    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 25) begin
        pick = $urandom_range(0, sent_x.size() - 1);
        x    = sent_x[pick];
        y    = sent_y[pick];
      end else if (r < 35) begin
        x = CW'($urandom_range(0, 15));
        y = CW'($urandom_range(0, 15));
      end else begin
        x = CW'($urandom());
        y = CW'($urandom());
      end
      send_point(x, y);
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== coordinate_hash_find_or_insert.f =====
rtl/chfi_pkg.sv
rtl/chfi_ram.sv
rtl/coordinate_hash_find_or_insert.sv
sim/find_or_insert_checker.sv
sim/testbench.sv
